// ===== rtl/urpd_pkg.sv =====
`default_nettype none
package urpd_pkg;

    localparam int NUM_SLOTS_DEFAULT = 8;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [15:0] HDR_LEN    = 16'd8;
    localparam logic [15:0] POS_MAX    = 16'hFFFF;
    localparam logic [15:0] POS_SRC_HI = 16'd0;
    localparam logic [15:0] POS_SRC_LO = 16'd1;
    localparam logic [15:0] POS_DST_HI = 16'd2;
    localparam logic [15:0] POS_DST_LO = 16'd3;
    localparam logic [15:0] POS_LEN_HI = 16'd4;
    localparam logic [15:0] POS_LEN_LO = 16'd5;
    localparam logic [15:0] POS_CHECK  = 16'd7;

    localparam logic OP_DATA     = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    typedef struct packed {
        logic        op;
        logic [7:0]  data_byte;
        logic [15:0] buffer_length;
        logic [31:0] source_address;
        logic [15:0] register_port;
        logic        buffer_end;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  handler_slot;
        logic [31:0] sender_address;
        logic [15:0] sender_port;
        logic [15:0] target_port;
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic [15:0] payload_length;
        logic        final_byte;
    } t_out_word;

    typedef enum logic [1:0] {
        CMD_REG  = 2'd0,
        CMD_EVAL = 2'd1,
        CMD_DATA = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  data_byte;
        logic [15:0] reg_port;
        logic [15:0] source_port;
        logic [15:0] tgt_port;
        logic [15:0] length;
        logic [31:0] address;
        logic        len_ok;
        logic        in_range;
        logic        last;
        logic        buffer_end;
    } t_cmd_word;

endpackage
`default_nettype wire

// ===== rtl/urpd_fifo.sv =====
`default_nettype none
module urpd_fifo #(
    parameter type t_word = logic,
    parameter int  DEPTH  = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_word i_wdata,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_word      o_rdata,
    output logic       o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_word            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W:0]   r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/urpd_front.sv =====
`default_nettype none
module urpd_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire urpd_pkg::t_in_word i_in_word,
    output logic                    o_cmd_push,
    output urpd_pkg::t_cmd_word     o_cmd_word
);
    import urpd_pkg::*;

    logic [15:0] r_pos, n_pos;
    logic [15:0] r_source_port;
    logic [15:0] r_tgt_port;
    logic [15:0] r_length;
    logic [31:0] r_address;
    logic        data_item;
    logic [16:0] pos_next;

    assign data_item = i_accept && (i_in_word.op == OP_DATA);
    assign pos_next  = {1'b0, r_pos} + 17'd1;

    always_comb begin
        o_cmd_word             = '0;
        o_cmd_word.data_byte   = i_in_word.data_byte;
        o_cmd_word.reg_port    = i_in_word.register_port;
        o_cmd_word.source_port = r_source_port;
        o_cmd_word.tgt_port    = r_tgt_port;
        o_cmd_word.length      = r_length;
        o_cmd_word.address     = r_address;
        o_cmd_word.buffer_end  = i_in_word.buffer_end;
        o_cmd_word.len_ok      = (i_in_word.buffer_length >= HDR_LEN) && (r_length >= HDR_LEN)
                                 && (r_length <= i_in_word.buffer_length);
        o_cmd_word.in_range    = (r_pos < r_length);
        o_cmd_word.last        = (pos_next == {1'b0, r_length}) || i_in_word.buffer_end;
        o_cmd_push             = 1'b0;
        if (i_in_word.op == OP_REGISTER) begin
            o_cmd_word.kind = CMD_REG;
            o_cmd_push      = i_accept;
        end else if (r_pos == POS_CHECK) begin
            o_cmd_word.kind = CMD_EVAL;
            o_cmd_push      = i_accept;
        end else begin
            // header bytes are absorbed here; only payload travels on
            o_cmd_word.kind = CMD_DATA;
            o_cmd_push      = i_accept && (r_pos > POS_CHECK);
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (data_item) begin
            if (i_in_word.buffer_end) begin
                n_pos = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = pos_next[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_item) begin
            case (r_pos)
                POS_SRC_HI: begin
                    r_address     <= i_in_word.source_address;
                    r_source_port <= {i_in_word.data_byte, 8'h00};
                end
                POS_SRC_LO: r_source_port <= {r_source_port[15:8], i_in_word.data_byte};
                POS_DST_HI: r_tgt_port    <= {i_in_word.data_byte, 8'h00};
                POS_DST_LO: r_tgt_port    <= {r_tgt_port[15:8], i_in_word.data_byte};
                POS_LEN_HI: r_length      <= {i_in_word.data_byte, 8'h00};
                POS_LEN_LO: r_length      <= {r_length[15:8], i_in_word.data_byte};
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/urpd_back.sv =====
`default_nettype none
module urpd_back #(
    parameter int NUM_SLOTS = urpd_pkg::NUM_SLOTS_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cmd_empty,
    input  wire urpd_pkg::t_cmd_word i_cmd_word,
    output logic                     o_cmd_pop,
    input  wire logic                i_res_full,
    output logic                     o_res_push,
    output urpd_pkg::t_out_word      o_res_word
);
    import urpd_pkg::*;

    logic [15:0]          r_slot_port [NUM_SLOTS];
    logic                 r_delivering, n_delivering;
    logic [2:0]           r_slot;
    logic [15:0]          r_source_port;
    logic [15:0]          r_tgt_port;
    logic [15:0]          r_pay_len;
    logic [31:0]          r_address;
    logic                 take;
    logic                 any_hit;
    logic [2:0]           hit_slot;
    logic [NUM_SLOTS-1:0] free_sel;
    logic                 free_found;
    logic                 is_eval, is_data, is_reg;
    logic                 eval_ok;
    logic                 emit_eval, emit_data;
    logic [15:0]          eval_pay_len;

    assign take      = ~i_cmd_empty & ~i_res_full;
    assign o_cmd_pop = take;
    assign is_eval   = take && (i_cmd_word.kind == CMD_EVAL);
    assign is_data   = take && (i_cmd_word.kind == CMD_DATA);
    assign is_reg    = take && (i_cmd_word.kind == CMD_REG);

    // lowest matching slot wins; lowest empty slot takes a registration
    always_comb begin
        any_hit    = 1'b0;
        hit_slot   = '0;
        free_sel   = '0;
        free_found = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_slot_port[i] != '0 && r_slot_port[i] == i_cmd_word.tgt_port) begin
                any_hit  = 1'b1;
                hit_slot = 3'(i);
            end
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!free_found && r_slot_port[i] == '0) begin
                free_sel[i] = 1'b1;
                free_found  = 1'b1;
            end
        end
    end

    assign eval_ok      = i_cmd_word.len_ok && any_hit;
    assign eval_pay_len = i_cmd_word.length - HDR_LEN;
    assign emit_eval    = is_eval && eval_ok && (i_cmd_word.length == HDR_LEN);
    assign emit_data    = is_data && r_delivering && i_cmd_word.in_range;
    assign o_res_push   = emit_eval || emit_data;

    always_comb begin
        o_res_word = '0;
        if (is_eval) begin
            o_res_word.handler_slot   = hit_slot;
            o_res_word.sender_address = i_cmd_word.address;
            o_res_word.sender_port    = i_cmd_word.source_port;
            o_res_word.target_port    = i_cmd_word.tgt_port;
            o_res_word.payload_length = eval_pay_len;
            o_res_word.final_byte     = 1'b1;
        end else begin
            o_res_word.handler_slot   = r_slot;
            o_res_word.sender_address = r_address;
            o_res_word.sender_port    = r_source_port;
            o_res_word.target_port    = r_tgt_port;
            o_res_word.payload_length = r_pay_len;
            o_res_word.payload_byte   = i_cmd_word.data_byte;
            o_res_word.byte_valid     = 1'b1;
            o_res_word.final_byte     = i_cmd_word.last;
        end
    end

    always_comb begin
        n_delivering = r_delivering;
        if (is_eval) begin
            n_delivering = eval_ok && (i_cmd_word.length != HDR_LEN)
                           && !i_cmd_word.buffer_end;
        end else if (is_data) begin
            if (i_cmd_word.buffer_end || (emit_data && i_cmd_word.last)) begin
                n_delivering = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delivering <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_slot_port[i] <= '0;
            end
        end else begin
            r_delivering <= n_delivering;
            if (is_reg && i_cmd_word.reg_port != '0) begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (free_sel[i]) begin
                        r_slot_port[i] <= i_cmd_word.reg_port;
                    end
                end
            end
        end
    end

    // hold the header of the datagram being delivered
    always_ff @(posedge i_clk) begin
        if (is_eval) begin
            r_source_port <= i_cmd_word.source_port;
            r_tgt_port    <= i_cmd_word.tgt_port;
            r_pay_len     <= eval_pay_len;
            r_address     <= i_cmd_word.address;
            if (eval_ok) begin
                r_slot <= hit_slot;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/udp_rx_port_demux.sv =====
// UDP receive port demultiplexer.
// Input queue side: present a word on i_in_word with push high; it is taken
// at a clock edge where full is low. A word is either one byte of a received
// datagram buffer or a request to register a port in the handler table.
// Output queue side: while empty is low the oldest result stands on
// o_out_word; pop high takes it. Each accepted datagram with a registered
// destination port gives one result per payload byte, or a single no-byte
// result for an empty payload; dropped datagrams give nothing.
// One word is accepted per cycle while full is low. A result passes through
// two registered queues: the command queue behind the header parser, then
// the result queue behind the port matcher, whose parallel compare over all
// slots sets the cycle. Both queues hold four words.
// When pop stays low, results gather in the result queue, the matcher then
// stops taking commands and full rises once the command queue fills.
// Reset empties both queues, clears the port table and restarts parsing;
// push may be raised in the first cycle after reset.
`default_nettype none
module udp_rx_port_demux #(
    parameter int NUM_SLOTS = urpd_pkg::NUM_SLOTS_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire urpd_pkg::t_in_word i_in_word,
    output logic                    empty,
    input  wire logic               pop,
    output urpd_pkg::t_out_word     o_out_word
);
    import urpd_pkg::*;

    logic      accept;
    logic      cmd_push, cmd_pop, cmd_empty;
    t_cmd_word cmd_in, cmd_out;
    logic      res_push, res_full;
    t_out_word res_in;

    assign accept = push & ~full;

    urpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in_word  (i_in_word),
        .o_cmd_push (cmd_push),
        .o_cmd_word (cmd_in)
    );

    urpd_fifo #(
        .t_word (t_cmd_word),
        .DEPTH  (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_wdata (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_rdata (cmd_out),
        .o_empty (cmd_empty)
    );

    urpd_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd_word  (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res_word  (res_in)
    );

    urpd_fifo #(
        .t_word (t_out_word),
        .DEPTH  (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (o_out_word),
        .o_empty (empty)
    );

    a_result_needs_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> (cmd_pop && !cmd_empty && !res_full))
        else $error("result written without a command taken");

    a_empty_payload_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_word.byte_valid) |-> o_out_word.final_byte)
        else $error("no-byte result not marked final");

    a_empty_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out_word.byte_valid) |-> (o_out_word.payload_byte == '0))
        else $error("no-byte result carries a byte");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule
`default_nettype wire
